FILE: rtl/pidc_pkg.sv
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SmoothW = 17;
  localparam int unsigned LimitW = 31;
  localparam int unsigned ModeW = 2;

  localparam logic [SmoothW-1:0] QOne = 17'd65536;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegProp = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInteg = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeriv = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSmooth = 3'd5;

  localparam logic [ModeW-1:0] ModePid = 2'd0;
  localparam logic [ModeW-1:0] ModePi = 2'd1;
  localparam logic [ModeW-1:0] ModePd = 2'd2;
  // The spare mode code behaves as PD.
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // Saturate a wide signed value to the 32-bit range.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > S32Max) r = 32'sh7fffffff;
    else if (v < S32Min) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

  // Request into the shift-add multiplier.
  typedef struct packed {
    logic               start;
    logic signed [63:0] mcand;
    logic [47:0]        mplier;
  } mul_req_t;

  // Request into the restoring divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [StepW-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/pidc_mul.sv
module pidc_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pidc_pkg::mul_req_t     req_i,
  output logic                   done_o,
  output logic signed [63:0]     prod_o
);
  import pidc_pkg::*;

  // Multiplier bits are consumed one per cycle, LSB first; the multiplier is
  // treated as unsigned (callers pass magnitudes or positive values).
  logic [47:0]        mplier_q;
  logic signed [63:0] mcand_q, acc_q;
  logic [5:0]         cnt_q;
  logic               busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mplier_q <= req_i.mplier;
      mcand_q  <= req_i.mcand;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mplier_q <= mplier_q >> 1;
      mcand_q  <= mcand_q <<< 1;
    end
  end

  assign prod_o = acc_q;

endmodule

FILE: rtl/pidc_div.sv
module pidc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pidc_pkg::div_req_t           req_i,
  output logic                         done_o,
  output logic [63:0]                  quot_o
);
  import pidc_pkg::*;

  // Restoring division, one quotient bit per cycle, MSB first.
  logic [63:0]      quot_q;
  logic [StepW:0]   rem_q;
  logic [StepW-1:0] dvs_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic [StepW:0]   trial;

  assign trial = {rem_q[StepW-1:0], quot_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q  <= trial - {1'b0, dvs_q};
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        rem_q  <= trial;
        quot_q <= {quot_q[62:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;

endmodule

FILE: rtl/pid_controller_antiwindup.sv
// Channel  Direction  Handshake          Payload
// cfg      in         cfg_valid/ready    cfg_index_i, cfg_data_i
// in       in         in_valid/stall     command_i, measured_i, target_i, step_time_i
// out      out        out_valid/stall    drive_o, clamped_o, zero_step_o
//
// One item at a time. A control step in PID or PD mode runs six bit-serial
// multiplies on the shared shift-add multiplier and, unless the step time
// is zero, one division on the serial divider; PI mode runs three
// multiplies and skips the derivative and its filter. A clear request is
// answered in the next cycle. Reset clears the controller's registers and
// stored terms, not the multiplier and divider data registers. The input is
// stalled while a step is in work, its result waits to be taken, or a
// configuration write is offered.
module pid_controller_antiwindup (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidc_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [pidc_pkg::DataW-1:0]             cfg_data_i,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   command_i,
  input  logic signed [pidc_pkg::DataW-1:0]      measured_i,
  input  logic signed [pidc_pkg::DataW-1:0]      target_i,
  input  logic [pidc_pkg::StepW-1:0]             step_time_i,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidc_pkg::DataW-1:0]      drive_o,
  output logic                                   clamped_o,
  output logic                                   zero_step_o
);
  import pidc_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StP, StI, StIMul, StDMul, StDDiv, StFilt1, StFilt2, StFilt3, StFin, StOut
  } state_e;

  state_e state_q;

  logic [ModeW-1:0]          mode_q;
  logic signed [DataW-1:0]   kp_q, ki_q, kd_q;
  logic [LimitW-1:0]         lim_q;
  logic [SmoothW-1:0]        smooth_q;
  logic signed [DataW-1:0]   last_err_q, fd_q, isum_q;
  logic signed [DataW-1:0]   err_q, p_q, d_q;
  logic signed [63:0]        inc_q, facc_q;
  logic [StepW-1:0]          dt_q;
  logic                      neg_q, zero_q;

  mul_req_t           mreq;
  div_req_t           dreq;
  logic               mdone, ddone;
  logic signed [63:0] mprod;
  logic [63:0]        dquot;

  pidc_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .prod_o(mprod));
  pidc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  assign cfg_ready = (state_q == StIdle);
  assign in_stall  = (state_q != StIdle) || cfg_valid;
  assign out_valid = (state_q == StOut);

  // Signed product of a 32-bit value and a gain: magnitude of the gain as
  // the serial multiplier operand.
  function automatic mul_req_t mk_mul(input logic signed [DataW-1:0] a,
                                      input logic signed [DataW-1:0] b);
    mul_req_t r;
    logic signed [63:0] bx;
    bx = 64'(b);
    r.start = 1'b1;
    if (b < 0) begin
      r.mcand  = -64'(a);
      r.mplier = 48'(-bx);
    end else begin
      r.mcand  = 64'(a);
      r.mplier = 48'(bx);
    end
    return r;
  endfunction

  logic signed [63:0] err_w, lim_s, hi_w, lo_w, isat_w, sum_w, pd_w, d_w;
  logic signed [63:0] qd_w;
  logic               use_d;

  always_comb begin
    err_w = 64'(target_i) - 64'(measured_i);
    lim_s = 64'($signed({1'b0, lim_q}));
    use_d = (mode_q != ModePi);
    qd_w  = '0;
    mreq  = '0;
    dreq  = '0;
    case (state_q)
      StIdle: if (in_valid && !cfg_valid && !command_i) mreq = mk_mul(sat32(err_w), kp_q);
      StP:    if (mdone) mreq = mk_mul(err_q, ki_q);
      StI:    if (mdone) begin
        mreq.start = 1'b1;
        mreq.mcand = 64'(sat32(mprod >>> 16));
        mreq.mplier = 48'(dt_q);
      end
      StIMul: if (mdone && use_d)
        mreq = mk_mul(sat32(64'(err_q) - 64'(last_err_q)), kd_q);
      StDMul: if (mdone && dt_q != '0) begin
        dreq.start = 1'b1;
        qd_w = 64'(sat32(mprod >>> 16));
        dreq.dividend = (qd_w < 0) ? 64'(-qd_w) << 24 : 64'(qd_w) << 24;
        dreq.divisor = dt_q;
      end
      StFilt1: begin
        mreq.start = 1'b1;
        mreq.mcand = 64'(fd_q);
        mreq.mplier = 48'(smooth_q);
      end
      StFilt2: if (mdone) begin
        mreq.start = 1'b1;
        mreq.mcand = 64'(d_q);
        mreq.mplier = 48'(QOne - smooth_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    d_w    = neg_q ? -$signed(dquot) : $signed(dquot);
    pd_w   = 64'(sat32(64'(p_q) + 64'(fd_q)));
    sum_w  = pd_w + 64'(isum_q) + inc_q;
    isat_w = 64'(sat32(64'(isum_q) + inc_q));
    hi_w   = 64'(sat32(lim_s - 64'(p_q)));
    lo_w   = 64'(sat32(-lim_s - 64'(p_q)));
    if (hi_w < 0) hi_w = '0;
    if (lo_w > 0) lo_w = '0;
  end

  // Sequencer for configuration writes and one request at a time; holds state, stored terms and the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= ModePid; kp_q <= '0; ki_q <= '0; kd_q <= '0;
      lim_q <= '0; smooth_q <= '0;
      last_err_q <= '0; fd_q <= '0; isum_q <= '0;
      err_q <= '0; p_q <= '0; d_q <= '0;
      inc_q <= '0; facc_q <= '0; dt_q <= '0; neg_q <= 1'b0; zero_q <= 1'b0;
      drive_o <= '0; clamped_o <= 1'b0; zero_step_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cfg_valid) begin
            if (cfg_index_i <= RegSmooth) isum_q <= '0;
            case (cfg_index_i)
              RegMode:   mode_q <= cfg_data_i[ModeW-1:0];
              RegProp:   kp_q <= cfg_data_i;
              RegInteg:  ki_q <= cfg_data_i;
              RegDeriv:  kd_q <= cfg_data_i;
              RegLimit:  lim_q <= cfg_data_i[LimitW-1:0];
              RegSmooth: smooth_q <= (cfg_data_i[SmoothW-1:0] > QOne) ? QOne
                                     : cfg_data_i[SmoothW-1:0];
              default: ;
            endcase
          end else if (in_valid) begin
            if (command_i) begin
              last_err_q <= '0; fd_q <= '0; isum_q <= '0;
              drive_o <= '0; clamped_o <= 1'b0; zero_step_o <= 1'b0;
              state_q <= StOut;
            end else begin
              err_q <= sat32(err_w);
              dt_q <= step_time_i;
              state_q <= StP;
            end
          end
        end
        StP: if (mdone) begin
          p_q <= sat32(mprod >>> 16);
          state_q <= StI;
        end
        StI: if (mdone) state_q <= StIMul;
        StIMul: if (mdone) begin
          inc_q <= mprod >>> 24;
          state_q <= use_d ? StDMul : StFin;
        end
        StDMul: if (mdone) begin
          neg_q <= (sat32(mprod >>> 16) < 0);
          last_err_q <= err_q;
          if (dt_q == '0) begin
            d_q <= '0; zero_q <= 1'b1;
            state_q <= StFilt1;
          end else begin
            zero_q <= 1'b0;
            state_q <= StDDiv;
          end
        end
        StDDiv: if (ddone) begin
          d_q <= sat32(d_w);
          state_q <= StFilt1;
        end
        StFilt1: state_q <= StFilt2;
        StFilt2: if (mdone) begin
          facc_q <= mprod;
          state_q <= StFilt3;
        end
        // Filter completes once the second product is in.
        StFilt3: if (mdone) begin
          fd_q <= sat32((facc_q + mprod) >>> 16);
          state_q <= StFin;
        end
        StFin: begin
          state_q <= StOut;
          zero_step_o <= use_d & zero_q;
          if (mode_q == ModePid) begin
            if (sum_w > lim_s) begin
              drive_o <= lim_s[DataW-1:0]; clamped_o <= 1'b1;
            end else if (sum_w < -lim_s) begin
              drive_o <= 32'(-lim_s); clamped_o <= 1'b1;
            end else begin
              drive_o <= sum_w[DataW-1:0]; clamped_o <= 1'b0;
              isum_q <= isat_w[DataW-1:0];
            end
          end else if (mode_q == ModePi) begin
            logic signed [63:0] ni, ps;
            ni = isat_w;
            if (ni > hi_w) ni = hi_w;
            else if (ni < lo_w) ni = lo_w;
            isum_q <= ni[DataW-1:0];
            ps = 64'(p_q) + ni;
            if (ps > lim_s) begin
              drive_o <= lim_s[DataW-1:0]; clamped_o <= 1'b1;
            end else if (ps < -lim_s) begin
              drive_o <= 32'(-lim_s); clamped_o <= 1'b1;
            end else begin
              drive_o <= ps[DataW-1:0]; clamped_o <= 1'b0;
            end
          end else begin
            logic signed [63:0] ps;
            ps = 64'(p_q) + 64'(fd_q);
            if (ps > lim_s) begin
              drive_o <= lim_s[DataW-1:0]; clamped_o <= 1'b1;
            end else if (ps < -lim_s) begin
              drive_o <= 32'(-lim_s); clamped_o <= 1'b1;
            end else begin
              drive_o <= ps[DataW-1:0]; clamped_o <= 1'b0;
            end
          end
        end
        StOut: if (!out_stall) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  // The result never exceeds the configured limit.
  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (64'(drive_o) <= lim_s) && (64'(drive_o) >= -lim_s))
    else $error("drive outside limit");
  // Clamped output sits exactly on a bound.
  a_clamp_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && clamped_o) |-> (64'(drive_o) == lim_s || 64'(drive_o) == -lim_s))
    else $error("clamp flag without bound");
  // A waiting result is held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(drive_o)))
    else $error("result dropped");
`endif

endmodule
